// ===== hdl/kpu_pkg.sv =====
`timescale 1ns / 1ps
package kpu_pkg;
    localparam int RankW = 45;
    localparam int ElemW = 4;
    localparam int LenW = 5;
    localparam int MaxElementsDef = 16;
    localparam int FactW = 64;
    localparam logic [LenW-1:0] LenReset = 5'd16;
    localparam int CfgAddrW = 1;
    localparam logic [CfgAddrW-1:0] RegPermLength = 1'b0;

    function automatic logic [FactW-1:0] fact_of(input logic [4:0] idx);
        logic [FactW-1:0] f;
        f = 64'd1;
        unique case (idx)
            5'd0, 5'd1: f = 64'd1;
            5'd2:  f = 64'd2;
            5'd3:  f = 64'd6;
            5'd4:  f = 64'd24;
            5'd5:  f = 64'd120;
            5'd6:  f = 64'd720;
            5'd7:  f = 64'd5040;
            5'd8:  f = 64'd40320;
            5'd9:  f = 64'd362880;
            5'd10: f = 64'd3628800;
            5'd11: f = 64'd39916800;
            5'd12: f = 64'd479001600;
            5'd13: f = 64'd6227020800;
            5'd14: f = 64'd87178291200;
            5'd15: f = 64'd1307674368000;
            5'd16: f = 64'd20922789888000;
            5'd17: f = 64'd355687428096000;
            5'd18: f = 64'd6402373705728000;
            5'd19: f = 64'd121645100408832000;
            default: f = 64'd1;
        endcase
        return f;
    endfunction
endpackage

// ===== hdl/kpu_if.sv =====
`timescale 1ns / 1ps
interface kpu_rank_if import kpu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RankW-1:0] rank;
    modport source (output valid, output rank, input ready);
    modport sink (input valid, input rank, output ready);
endinterface

interface kpu_elem_if import kpu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ElemW-1:0] perm_element;
    logic [ElemW-1:0] element_position;
    logic             rank_clamped;
    logic             last_element;
    modport source (output valid, output perm_element, output element_position,
                    output rank_clamped, output last_element, input ready);
    modport sink (input valid, input perm_element, input element_position,
                  input rank_clamped, input last_element, output ready);
endinterface

// ===== hdl/kpu_cell.sv =====
`timescale 1ns / 1ps
// One slot of the pool of unused values. On a removal every slot at or above
// the removed place takes its upper neighbor's value.
module kpu_cell import kpu_pkg::*; #(
    parameter int IdxW = 5
) (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic [IdxW-1:0] i_init,
    input  logic            i_shift,
    input  logic [IdxW-1:0] i_upper,
    output logic [IdxW-1:0] o_value
);
    logic [IdxW-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_init;
        end else if (i_shift) begin
            r_value <= i_upper;
        end
    end

    assign o_value = r_value;
endmodule

// ===== hdl/kth_permutation_unrank.sv =====
`timescale 1ns / 1ps
// Lexicographic permutation unranking.
// A rank k is taken on the input channel as one transfer; the block then gives
// n result transfers, one per position, carrying the value at that position of
// the k-th lexicographic permutation of 0..n-1, its position, a clamp flag and
// a last flag. n is the perm_length register on the APB port (reset value 16),
// saturated to MAX_ELEMENTS; with n equal to zero a rank gives no results.
// Each position finds its quotient by repeated subtraction of (n-1-i)! from
// the remainder, one subtraction per cycle, giving the chosen index q (at most
// n-1-i for a rank below n!); the chosen value is then pulled out of the pool.
// The pool is a row of cells that shift toward the low end by one place when a
// value is removed.
// A rank of n! or more is known to clamp once the count reaches the number of
// unused values; the remainder is then reduced by a shift-and-subtract pass
// over the 45 rank bits.
// The block works on one rank at a time; input ready is high only when idle.
// When the receiver stalls, the result register holds and the block waits.
// Reset (synchronous, active low) drops any rank in flight and sets n to 16.
module kth_permutation_unrank import kpu_pkg::*; #(
    parameter int MAX_ELEMENTS = MaxElementsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kpu_rank_if.sink           i_rank,
    kpu_elem_if.source         o_elem,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CfgAddrW+1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int IdxW = $clog2(MAX_ELEMENTS + 1);
    localparam int SelW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CntW = $clog2(RankW);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT, S_MOD} t_state;

    t_state             r_state;
    logic [LenW-1:0]    r_len;
    logic [IdxW-1:0]    r_n;
    logic [IdxW-1:0]    r_pos;
    logic [IdxW-1:0]    r_q;
    logic [FactW-1:0]   r_rem;
    logic [FactW-1:0]   r_fact;
    logic [RankW-1:0]   r_dvd;
    logic [CntW-1:0]    r_cnt;
    logic               r_vld;
    logic [ElemW-1:0]   r_elem;
    logic [ElemW-1:0]   r_epos;
    logic               r_clamp;
    logic               r_last;

    logic [IdxW-1:0]    w_val [MAX_ELEMENTS];
    logic               w_load;
    logic               w_shift;
    logic [IdxW-1:0]    w_left;
    logic [IdxW-1:0]    w_sel;
    logic               w_clamp;
    logic [IdxW-1:0]    w_neff;
    logic [4:0]         w_fidx;
    logic [FactW-1:0]   w_try;
    logic [FactW-1:0]   n_rem;

    assign pready = 1'b1;
    assign prdata = (paddr[CfgAddrW+1:2] == RegPermLength) ? {27'd0, r_len} : 32'd0;

    always_comb begin
        if (r_len > LenW'(MAX_ELEMENTS)) begin
            w_neff = IdxW'(MAX_ELEMENTS);
        end else begin
            w_neff = IdxW'(r_len);
        end
    end

    assign w_left  = r_n - r_pos;
    assign w_clamp = (r_q >= w_left);
    assign w_sel   = w_clamp ? (w_left - IdxW'(1)) : r_q;
    assign w_load  = (r_state == S_IDLE) && i_rank.valid;
    assign w_shift = (r_state == S_DIV) && (r_rem < r_fact) && (!r_vld || o_elem.ready);
    assign w_fidx  = 5'(r_n - r_pos - IdxW'(2));

    // One step of the long division that reduces an oversized rank: the
    // partial remainder takes the next rank bit and drops the factorial once.
    assign w_try = {r_rem[FactW-2:0], r_dvd[RankW-1]};
    assign n_rem = (w_try >= r_fact) ? (w_try - r_fact) : w_try;

    genvar g;
    generate
        for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
            logic [IdxW-1:0] w_up;
            if (g == MAX_ELEMENTS - 1) begin : g_top
                assign w_up = '0;
            end else begin : g_mid
                assign w_up = w_val[g+1];
            end
            kpu_cell #(.IdxW(IdxW)) u_cell (
                .i_clk  (i_clk),
                .i_load (w_load),
                .i_init (IdxW'(g)),
                .i_shift(w_shift && (IdxW'(g) >= w_sel)),
                .i_upper(w_up),
                .o_value(w_val[g])
            );
        end
    endgenerate

    assign i_rank.ready          = (r_state == S_IDLE);
    assign o_elem.valid          = r_vld;
    assign o_elem.perm_element   = r_elem;
    assign o_elem.element_position = r_epos;
    assign o_elem.rank_clamped   = r_clamp;
    assign o_elem.last_element   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LenReset;
            r_vld   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[CfgAddrW+1:2] == RegPermLength) begin
                r_len <= pwdata[LenW-1:0];
            end
            if (r_vld && o_elem.ready && !w_shift) begin
                r_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_rank.valid && w_neff != '0) begin
                        r_state <= S_DIV;
                        r_n     <= w_neff;
                        r_pos   <= '0;
                        r_q     <= '0;
                        r_rem   <= FactW'(i_rank.rank);
                        r_fact  <= fact_of(5'(w_neff - IdxW'(1)));
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_fact) begin
                        if (r_q >= w_left) begin
                            // The position clamps; only the remainder is
                            // still needed, so finish it by long division.
                            r_state <= S_MOD;
                            r_dvd   <= r_rem[RankW-1:0];
                            r_rem   <= '0;
                            r_cnt   <= '0;
                        end else begin
                            r_rem <= r_rem - r_fact;
                            r_q   <= r_q + IdxW'(1);
                        end
                    end else if (!r_vld || o_elem.ready) begin
                        r_vld   <= 1'b1;
                        r_elem  <= ElemW'(w_val[w_sel[SelW-1:0]]);
                        r_epos  <= ElemW'(r_pos);
                        r_clamp <= w_clamp;
                        r_last  <= (r_pos == r_n - IdxW'(1));
                        r_q     <= '0;
                        r_pos   <= r_pos + IdxW'(1);
                        if (r_pos == r_n - IdxW'(1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_fact <= fact_of(w_fidx);
                        end
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[RankW-2:0], 1'b0};
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == CntW'(RankW - 1)) begin
                        r_state <= S_DIV;
                    end
                end
                S_OUT: begin
                    if (!r_vld || o_elem.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
